FILE: design/mqtt_connect_framer_macros.svh
// Assertion macros used by the framer back end.
`ifndef MQTT_CONNECT_FRAMER_MACROS_SVH
`define MQTT_CONNECT_FRAMER_MACROS_SVH

`ifndef SYNTH
`define MCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MCF_ASSERT_NOW(lbl, ante, cons, msg)
`define MCF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/mcf_pkg.sv
// Types, constants and codes of the MQTT connect framer.
package mcf_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int REM_W = 18;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int HDR_LEN = 10;
  localparam int HDR_IDX_W = $clog2(HDR_LEN);

  localparam logic [7:0] FRAME_TYPE = 8'h10;
  localparam logic [7:0] CONNECT_FLAGS = 8'hC2;
  localparam logic [7:0] KEEP_ALIVE = 8'd120;
  localparam logic [7:0] PROTO_LEVEL = 8'd4;
  localparam logic [7:0] MAX_RESPONSE = 8'd200;
  localparam logic [7:0] MIN_ACK_LEN = 8'd4;
  localparam logic [3:0] FAIL_SAT = 4'd15;
  localparam logic [REM_W-1:0] REM_FIXED = REM_W'(16);

  typedef enum logic [1:0] {
    ACT_START    = 2'd0,
    ACT_STRING   = 2'd1,
    ACT_RESPONSE = 2'd2,
    ACT_FAIL     = 2'd3
  } mcf_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CID   = 3'd0,
    CFG_USER  = 3'd1,
    CFG_PASS  = 3'd2,
    CFG_ACK1  = 3'd3,
    CFG_ACK2  = 3'd4,
    CFG_LIMIT = 3'd5
  } mcf_cfg_idx_t;

  typedef enum logic [1:0] {
    VERD_ACCEPTED = 2'd0,
    VERD_RETRY    = 2'd1,
    VERD_GIVEN_UP = 2'd2
  } mcf_verdict_t;

  typedef enum logic [1:0] {
    SEC_IDLE = 2'd0,
    SEC_CID  = 2'd1,
    SEC_USER = 2'd2,
    SEC_PASS = 2'd3
  } mcf_section_t;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_VERDICT = 2'd2
  } mcf_cmd_kind_t;

  typedef enum logic [3:0] {
    PH_TYPE,
    PH_LEN0,
    PH_LEN1,
    PH_LEN2,
    PH_HDR,
    PH_PFX_HI,
    PH_PFX_LO,
    PH_DATA,
    PH_VERDICT
  } mcf_phase_t;

  // next_fld: 0 no prefix follows, 1..3 prefixes from that field on, 4 frame ends
  typedef struct packed {
    mcf_cmd_kind_t kind;
    logic [7:0]    data;
    logic [2:0]    next_fld;
    mcf_verdict_t  verdict;
  } mcf_cmd_t;

  typedef struct packed {
    logic [15:0] cid_len;
    logic [15:0] user_len;
    logic [15:0] pass_len;
    logic [7:0]  ack1;
    logic [7:0]  ack2;
    logic [3:0]  limit;
  } mcf_cfg_t;

  function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0: b = 8'h00;
      4'd1: b = 8'h04;
      4'd2: b = 8'h4D;
      4'd3: b = 8'h51;
      4'd4: b = 8'h54;
      4'd5: b = 8'h54;
      4'd6: b = PROTO_LEVEL;
      4'd7: b = CONNECT_FLAGS;
      4'd8: b = 8'h00;
      4'd9: b = KEEP_ALIVE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/mcf_in_if.sv
// Input word channel: action, data byte and response end mark.
interface mcf_in_if import mcf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       response_end;

  modport source (output valid, action, data_byte, response_end, input ready);
  modport sink (input valid, action, data_byte, response_end, output ready);
endinterface

FILE: design/mcf_out_if.sv
// Result word channel: frame bytes and acknowledgement verdicts.
interface mcf_out_if import mcf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       frame_done;
  logic [1:0] verdict;
  logic       last_in_run;

  modport source (output valid, out_kind, out_byte, frame_done, verdict, last_in_run,
                  input ready);
  modport sink (input valid, out_kind, out_byte, frame_done, verdict, last_in_run,
                output ready);
endinterface

FILE: design/mcf_cfg_if.sv
// Configuration write channel: register index and write data.
interface mcf_cfg_if import mcf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/mcf_front.sv
// Front end: accepts input words, tracks frame and response state, queues commands.
module mcf_front import mcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  mcf_in_if.sink   in_ch,
  input  mcf_cfg_t cfg,
  input  logic     q_full,
  output logic     q_push,
  output mcf_cmd_t q_data
);

  mcf_section_t section_r, section_nxt;
  logic [15:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]   resp_cnt_r, resp_cnt_nxt;
  logic         hm_r, hm_nxt;
  logic [3:0]   failed_r, failed_nxt;

  mcf_section_t ent_sec;
  logic [15:0]  ent_len;
  logic [2:0]   ent_from;
  logic         fire, push;
  logic         v_ok;
  logic [3:0]   fail_inc, lim;
  logic [7:0]   cnt_upd;
  logic         hm_upd;

  assign in_ch.ready = !q_full;
  assign fire = in_ch.valid && in_ch.ready;
  assign q_push = fire && push;

  // first field from ent_from on that has bytes
  always_comb begin
    priority if (ent_from <= 3'd1 && cfg.cid_len != 16'd0) begin
      ent_sec = SEC_CID;
      ent_len = cfg.cid_len;
    end else if (ent_from <= 3'd2 && cfg.user_len != 16'd0) begin
      ent_sec = SEC_USER;
      ent_len = cfg.user_len;
    end else if (ent_from <= 3'd3 && cfg.pass_len != 16'd0) begin
      ent_sec = SEC_PASS;
      ent_len = cfg.pass_len;
    end else begin
      ent_sec = SEC_IDLE;
      ent_len = 16'd0;
    end
  end

  assign fail_inc = (failed_r == FAIL_SAT) ? FAIL_SAT : failed_r + 4'd1;
  assign lim = (cfg.limit == 4'd0) ? 4'd1 : cfg.limit;

  always_comb begin
    hm_upd = hm_r;
    cnt_upd = resp_cnt_r;
    if (resp_cnt_r < MAX_RESPONSE) begin
      if (resp_cnt_r == 8'd0 && in_ch.data_byte != cfg.ack1) hm_upd = 1'b0;
      if (resp_cnt_r == 8'd1 && in_ch.data_byte != cfg.ack2) hm_upd = 1'b0;
      cnt_upd = resp_cnt_r + 8'd1;
    end else begin
      hm_upd = 1'b0;
    end
  end

  always_comb begin
    section_nxt = section_r;
    bytes_left_nxt = bytes_left_r;
    resp_cnt_nxt = resp_cnt_r;
    hm_nxt = hm_r;
    failed_nxt = failed_r;
    push = 1'b0;
    v_ok = 1'b0;
    ent_from = 3'd1;
    q_data.kind = CMD_START;
    q_data.data = in_ch.data_byte;
    q_data.next_fld = 3'd0;
    q_data.verdict = VERD_ACCEPTED;
    unique case (mcf_action_t'(in_ch.action))
      ACT_START: begin
        failed_nxt = 4'd0;
        resp_cnt_nxt = 8'd0;
        hm_nxt = 1'b1;
        ent_from = 3'd1;
        section_nxt = ent_sec;
        bytes_left_nxt = ent_len;
        push = 1'b1;
        q_data.next_fld = 3'd1;
      end
      ACT_STRING: begin
        ent_from = {1'b0, section_r} + 3'd1;
        if (section_r != SEC_IDLE && bytes_left_r != 16'd0) begin
          push = 1'b1;
          q_data.kind = CMD_BYTE;
          bytes_left_nxt = bytes_left_r - 16'd1;
          if (bytes_left_r == 16'd1) begin
            q_data.next_fld = ent_from;
            section_nxt = ent_sec;
            bytes_left_nxt = ent_len;
          end
        end
      end
      ACT_RESPONSE: begin
        hm_nxt = hm_upd;
        resp_cnt_nxt = cnt_upd;
        if (in_ch.response_end) begin
          push = 1'b1;
          v_ok = hm_upd && (cnt_upd >= MIN_ACK_LEN);
          resp_cnt_nxt = 8'd0;
          hm_nxt = 1'b1;
        end
      end
      ACT_FAIL: begin
        push = 1'b1;
        resp_cnt_nxt = 8'd0;
        hm_nxt = 1'b1;
      end
    endcase
    if (push && (mcf_action_t'(in_ch.action) == ACT_RESPONSE ||
                 mcf_action_t'(in_ch.action) == ACT_FAIL)) begin
      q_data.kind = CMD_VERDICT;
      if (v_ok) begin
        failed_nxt = 4'd0;
        q_data.verdict = VERD_ACCEPTED;
      end else begin
        failed_nxt = fail_inc;
        q_data.verdict = (fail_inc >= lim) ? VERD_GIVEN_UP : VERD_RETRY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r <= SEC_IDLE;
      bytes_left_r <= 16'd0;
      resp_cnt_r <= 8'd0;
      hm_r <= 1'b1;
      failed_r <= 4'd0;
    end else if (fire) begin
      section_r <= section_nxt;
      bytes_left_r <= bytes_left_nxt;
      resp_cnt_r <= resp_cnt_nxt;
      hm_r <= hm_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

FILE: design/mcf_queue.sv
// Short command queue between the front end and the byte sequencer.
module mcf_queue import mcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  mcf_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output mcf_cmd_t data
);

  mcf_cmd_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign full = (count_r == QCNT_W'(QDEPTH));
  assign valid = (count_r != '0);
  assign data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop) count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

FILE: design/mcf_back.sv
// Back end: expands queued commands into output words, one per cycle unless the output stalls.
`include "mqtt_connect_framer_macros.svh"
module mcf_back import mcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mcf_cfg_t cfg,
  input  logic     q_valid,
  input  mcf_cmd_t q_data,
  output logic     q_pop,
  mcf_out_if.source out_ch
);

  mcf_cmd_t             cmd_r;
  logic                 cmd_valid_r;
  mcf_phase_t           ph_r, ph_nxt;
  logic [HDR_IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]           fld_r, fld_nxt;

  logic                 out_valid_r;
  logic                 kind_r, done_r, last_r;
  logic [7:0]           byte_r;
  logic [1:0]           verd_r;

  logic [REM_W-1:0]     rem;
  logic [15:0]          fld_len;
  logic                 emit, load, last;
  logic                 o_kind, o_done;
  logic [7:0]           o_byte;
  logic [1:0]           o_verd;

  assign rem = REM_FIXED + REM_W'(cfg.cid_len) + REM_W'(cfg.user_len)
             + REM_W'(cfg.pass_len);

  always_comb begin
    unique case (fld_r)
      2'd1: fld_len = cfg.cid_len;
      2'd2: fld_len = cfg.user_len;
      default: fld_len = cfg.pass_len;
    endcase
  end

  assign emit = cmd_valid_r && (!out_valid_r || out_ch.ready);
  assign load = !cmd_valid_r || (emit && last);
  assign q_pop = load && q_valid;

  // next phase
  always_comb begin
    ph_nxt = ph_r;
    idx_nxt = idx_r;
    fld_nxt = fld_r;
    last = 1'b0;
    unique case (ph_r)
      PH_TYPE: ph_nxt = PH_LEN0;
      PH_LEN0: begin
        idx_nxt = '0;
        ph_nxt = (rem[REM_W-1:7] != '0) ? PH_LEN1 : PH_HDR;
      end
      PH_LEN1: begin
        idx_nxt = '0;
        ph_nxt = (rem[REM_W-1:14] != '0) ? PH_LEN2 : PH_HDR;
      end
      PH_LEN2: begin
        idx_nxt = '0;
        ph_nxt = PH_HDR;
      end
      PH_HDR: begin
        if (idx_r == HDR_IDX_W'(HDR_LEN - 1)) begin
          ph_nxt = PH_PFX_HI;
          fld_nxt = cmd_r.next_fld[1:0];
        end else begin
          idx_nxt = idx_r + HDR_IDX_W'(1);
        end
      end
      PH_PFX_HI: ph_nxt = PH_PFX_LO;
      PH_PFX_LO: begin
        if (fld_len != 16'd0 || fld_r == 2'd3) begin
          last = 1'b1;
        end else begin
          ph_nxt = PH_PFX_HI;
          fld_nxt = fld_r + 2'd1;
        end
      end
      PH_DATA: begin
        if (cmd_r.next_fld == 3'd0 || cmd_r.next_fld == 3'd4) begin
          last = 1'b1;
        end else begin
          ph_nxt = PH_PFX_HI;
          fld_nxt = cmd_r.next_fld[1:0];
        end
      end
      PH_VERDICT: last = 1'b1;
      default: last = 1'b1;
    endcase
  end

  // output word
  always_comb begin
    o_kind = 1'b0;
    o_byte = 8'h00;
    o_done = 1'b0;
    o_verd = VERD_ACCEPTED;
    unique case (ph_r)
      PH_TYPE: o_byte = FRAME_TYPE;
      PH_LEN0: o_byte = {rem[REM_W-1:7] != '0, rem[6:0]};
      PH_LEN1: o_byte = {rem[REM_W-1:14] != '0, rem[13:7]};
      PH_LEN2: o_byte = 8'(rem[REM_W-1:14]);
      PH_HDR: o_byte = hdr_byte(idx_r);
      PH_PFX_HI: o_byte = fld_len[15:8];
      PH_PFX_LO: begin
        o_byte = fld_len[7:0];
        o_done = (fld_len == 16'd0) && (fld_r == 2'd3);
      end
      PH_DATA: begin
        o_byte = cmd_r.data;
        o_done = (cmd_r.next_fld == 3'd4);
      end
      PH_VERDICT: begin
        o_kind = 1'b1;
        o_verd = cmd_r.verdict;
      end
      default: o_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      ph_r <= PH_TYPE;
      idx_r <= '0;
      fld_r <= 2'd1;
    end else if (load) begin
      cmd_valid_r <= q_valid;
      cmd_r <= q_data;
      idx_r <= '0;
      fld_r <= q_data.next_fld[1:0];
      unique case (q_data.kind)
        CMD_START: ph_r <= PH_TYPE;
        CMD_BYTE: ph_r <= PH_DATA;
        default: ph_r <= PH_VERDICT;
      endcase
    end else if (emit) begin
      ph_r <= ph_nxt;
      idx_r <= idx_nxt;
      fld_r <= fld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= o_kind;
      byte_r <= o_byte;
      done_r <= o_done;
      verd_r <= o_verd;
      last_r <= last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_kind = kind_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.frame_done = done_r;
  assign out_ch.verdict = verd_r;
  assign out_ch.last_in_run = last_r;

  `MCF_ASSERT_NOW(a_verdict_last, out_valid_r && kind_r, last_r && !done_r, "verdict not last")
  `MCF_ASSERT_NOW(a_done_last, out_valid_r && done_r, last_r && !kind_r, "frame end not last")
  `MCF_ASSERT_NOW(a_hdr_idx, cmd_valid_r && ph_r == PH_HDR, idx_r < HDR_IDX_W'(HDR_LEN), "hdr index")
  `MCF_ASSERT_NEXT(a_drain, emit && last && !q_valid, !cmd_valid_r, "sequencer stuck busy")

endmodule

FILE: design/mqtt_connect_framer.sv
// Top level of the MQTT connect framer: configuration registers, front end, queue, back end.
//
// Input words are accepted one per cycle whenever the four-entry command queue has room.
// The back end sequencer then emits one output word per cycle while the output register
// drains: a start word expands to 14 to 20 output words (type byte, one to three length
// bytes, ten header bytes and two to six prefix bytes), a string byte to one word plus up
// to four prefix words, and a response end or a receive failure to one verdict word.
// Sustained throughput is therefore set by the back end at one output word per cycle;
// configuration writes are taken in any cycle and should be made while the block is idle.
module mqtt_connect_framer import mcf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mcf_in_if.sink    in_ch,
  mcf_out_if.source out_ch,
  mcf_cfg_if.sink   cfg_ch
);

  mcf_cfg_t cfg_r;
  logic     q_full, q_push, q_pop, q_valid;
  mcf_cmd_t q_in, q_out;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cid_len <= 16'd0;
      cfg_r.user_len <= 16'd0;
      cfg_r.pass_len <= 16'd0;
      cfg_r.ack1 <= 8'd32;
      cfg_r.ack2 <= 8'd2;
      cfg_r.limit <= 4'd5;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (mcf_cfg_idx_t'(cfg_ch.index))
        CFG_CID: cfg_r.cid_len <= cfg_ch.data;
        CFG_USER: cfg_r.user_len <= cfg_ch.data;
        CFG_PASS: cfg_r.pass_len <= cfg_ch.data;
        CFG_ACK1: cfg_r.ack1 <= cfg_ch.data[7:0];
        CFG_ACK2: cfg_r.ack2 <= cfg_ch.data[7:0];
        CFG_LIMIT: cfg_r.limit <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  mcf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  mcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_out)
  );

  mcf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: verif/mqtt_connect_framer_test.sv
// Self-checking testbench for mqtt_connect_framer: predicts frame bytes and verdicts per word.
module mqtt_connect_framer_test import mcf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 1000;
  localparam int TOTAL_ITEMS = 260;

  typedef struct packed {
    mcf_action_t act;
    logic [7:0]  data;
    logic        rend;
  } in_word_t;

  typedef struct packed {
    logic         kind;
    logic [7:0]   octet;
    logic         done;
    mcf_verdict_t verd;
    logic         last;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mcf_in_if  in_ch();
  mcf_out_if out_ch();
  mcf_cfg_if cfg_ch();

  mqtt_connect_framer u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  in_word_t    pending[$];
  frame_word_t frame_expect[$];
  frame_word_t step_words[$];
  in_word_t    cur_word;
  bit          in_taken;
  bit          steady;
  int          errors;
  int          stall_cycles;
  int          queued;

  // register shadows
  logic [15:0] cid_len, user_len, pass_len;
  logic [7:0]  ack1, ack2;
  logic [3:0]  fail_limit;

  // framer state
  mcf_section_t sec;
  logic [15:0]  left;
  logic [7:0]   resp_cnt;
  logic         hdr_ok;
  logic [3:0]   fails;

  function automatic void emit(logic kind, logic [7:0] octet, mcf_verdict_t verd);
    frame_word_t w;
    w.kind = kind;
    w.octet = octet;
    w.done = 1'b0;
    w.verd = verd;
    w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic logic [15:0] field_len(int s);
    case (s)
      1: return cid_len;
      2: return user_len;
      default: return pass_len;
    endcase
  endfunction

  // prefixes from field s on, up to the first field with bytes to pass
  function automatic void open_field(int s);
    logic [15:0] len;
    while (s <= 3) begin
      len = field_len(s);
      emit(1'b0, len[15:8], VERD_ACCEPTED);
      emit(1'b0, len[7:0], VERD_ACCEPTED);
      if (len != 16'd0) begin
        sec = mcf_section_t'(s);
        left = len;
        return;
      end
      s++;
    end
    sec = SEC_IDLE;
    left = '0;
    step_words[step_words.size() - 1].done = 1'b1;
  endfunction

  function automatic void judge(bit ok);
    int lim;
    lim = (fail_limit == 4'd0) ? 1 : int'(fail_limit);
    if (ok) begin
      fails = '0;
      emit(1'b1, 8'h00, VERD_ACCEPTED);
    end else begin
      if (fails < FAIL_SAT) fails++;
      emit(1'b1, 8'h00, (int'(fails) >= lim) ? VERD_GIVEN_UP : VERD_RETRY);
    end
    resp_cnt = '0;
    hdr_ok = 1'b1;
  endfunction

  function automatic void frame_step(in_word_t w);
    int rem;
    logic [7:0] b;
    logic [7:0] hdr [10];
    hdr = '{8'h00, 8'h04, 8'h4D, 8'h51, 8'h54, 8'h54, PROTO_LEVEL, CONNECT_FLAGS, 8'h00,
            KEEP_ALIVE};
    step_words.delete();
    case (w.act)
      ACT_START: begin
        rem = 16 + int'(cid_len) + int'(user_len) + int'(pass_len);
        fails = '0;
        resp_cnt = '0;
        hdr_ok = 1'b1;
        emit(1'b0, FRAME_TYPE, VERD_ACCEPTED);
        do begin
          b = 8'(rem % 128);
          rem = rem / 128;
          if (rem > 0) b[7] = 1'b1;
          emit(1'b0, b, VERD_ACCEPTED);
        end while (rem > 0);
        foreach (hdr[i]) emit(1'b0, hdr[i], VERD_ACCEPTED);
        open_field(1);
      end
      ACT_STRING: begin
        if (sec != SEC_IDLE && left != 16'd0) begin
          emit(1'b0, w.data, VERD_ACCEPTED);
          left--;
          if (left == 16'd0) open_field(int'(sec) + 1);
        end
      end
      ACT_RESPONSE: begin
        if (resp_cnt < MAX_RESPONSE) begin
          if (resp_cnt == 8'd0 && w.data != ack1) hdr_ok = 1'b0;
          if (resp_cnt == 8'd1 && w.data != ack2) hdr_ok = 1'b0;
          resp_cnt++;
        end else begin
          hdr_ok = 1'b0;
        end
        if (w.rend) judge(hdr_ok && resp_cnt >= MIN_ACK_LEN);
      end
      default: judge(1'b0);
    endcase
    if (step_words.size() > 0) begin
      step_words[step_words.size() - 1].last = 1'b1;
      foreach (step_words[i]) frame_expect.push_back(step_words[i]);
    end
  endfunction

  function automatic void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want_v, got_v);
      errors++;
    end
  endfunction

  // acceptance, prediction, result checking and stall watchdog
  always @(posedge clk) begin
    frame_word_t want;
    if (rst_n) begin
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) frame_step(cur_word);
      if (out_ch.valid && out_ch.ready) begin
        if (frame_expect.size() == 0) begin
          $error("unexpected result word: kind %0d byte 0x%02h verdict %0d",
                 out_ch.out_kind, out_ch.out_byte, out_ch.verdict);
          errors++;
        end else begin
          want = frame_expect.pop_front();
          compare_field("out_kind", 8'(want.kind), 8'(out_ch.out_kind));
          compare_field("out_byte", want.octet, out_ch.out_byte);
          compare_field("frame_done", 8'(want.done), 8'(out_ch.frame_done));
          compare_field("verdict", 8'(want.verd), 8'(out_ch.verdict));
          compare_field("last_in_run", 8'(want.last), 8'(out_ch.last_in_run));
        end
      end
      if (in_taken || (out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
          $display("mqtt_connect_framer_test: done, errors");
          $finish;
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n && (in_taken || !in_ch.valid)) begin
      if (pending.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
        cur_word = pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= cur_word.act;
        in_ch.data_byte <= cur_word.data;
        in_ch.response_end <= cur_word.rend;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) out_ch.ready <= steady || ($urandom_range(99) >= 24);

  function automatic void queue_word(mcf_action_t act, logic [7:0] data, logic rend);
    in_word_t w;
    w.act = act;
    w.data = data;
    w.rend = rend;
    pending.push_back(w);
    queued++;
  endfunction

  function automatic void queue_strings(int n);
    for (int i = 0; i < n; i++) queue_word(ACT_STRING, 8'($urandom), 1'($urandom));
  endfunction

  function automatic void queue_response(logic [7:0] first, logic [7:0] second, int len);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      d = (i == 0) ? first : (i == 1) ? second : 8'($urandom);
      queue_word(ACT_RESPONSE, d, i == len - 1);
    end
  endfunction

  // one random sequence; returns the number of words that do something
  function automatic int queue_sequence(int frame_len);
    int pick, n;
    mcf_action_t act;
    pick = $urandom_range(99);
    if (pick < 40) begin
      queue_word(ACT_START, 8'($urandom), 1'($urandom));
      n = frame_len;
      if ($urandom_range(9) == 0) n = $urandom_range(frame_len);
      queue_strings(n);
      return n + 1;
    end else if (pick < 72) begin
      n = $urandom_range(1, 7);
      queue_response(($urandom_range(4) == 0) ? 8'($urandom) : ack1,
                     ($urandom_range(4) == 0) ? 8'($urandom) : ack2, n);
      return n;
    end else if (pick < 86) begin
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) queue_word(ACT_RESPONSE, 8'($urandom), 1'b0);
      queue_word(ACT_FAIL, 8'($urandom), 1'($urandom));
      return n + 1;
    end
    act = mcf_action_t'($urandom_range(3));
    queue_word(act, 8'($urandom), 1'($urandom));
    return (act == ACT_STRING) ? 0 : 1;
  endfunction

  task automatic write_reg(mcf_cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_CID:   cid_len = value;
      CFG_USER:  user_len = value;
      CFG_PASS:  pass_len = value;
      CFG_ACK1:  ack1 = value[7:0];
      CFG_ACK2:  ack2 = value[7:0];
      CFG_LIMIT: fail_limit = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // hold off until every word went in and every result came out
  task automatic settle();
    while (pending.size() != 0 || in_ch.valid || frame_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase, n, total;
    logic [15:0] lens [3];
    in_ch.valid = 1'b0;
    in_ch.action = ACT_START;
    in_ch.data_byte = 8'h00;
    in_ch.response_end = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CID;
    cfg_ch.data = 16'h0000;
    errors = 0;
    stall_cycles = 0;
    queued = 0;
    steady = 1'b0;
    in_taken = 1'b0;
    cid_len = '0;
    user_len = '0;
    pass_len = '0;
    ack1 = 8'd32;
    ack2 = 8'd2;
    fail_limit = 4'd5;
    sec = SEC_IDLE;
    left = '0;
    resp_cnt = '0;
    hdr_ok = 1'b1;
    fails = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty fields: whole frame from the start word
    queue_word(ACT_START, 8'hFF, 1'b1);
    queue_word(ACT_STRING, 8'hA5, 1'b0);
    queue_response(ack1, ack2, 4);
    queue_response(ack1, ack2, 2);
    queue_response(~ack1, ack2, 4);
    queue_word(ACT_RESPONSE, ack1, 1'b0);
    queue_word(ACT_FAIL, 8'h00, 1'b0);
    settle();

    write_reg(CFG_CID, 16'd3);
    write_reg(CFG_USER, 16'd0);
    write_reg(CFG_PASS, 16'd2);
    write_reg(CFG_ACK1, 16'h0000);
    write_reg(CFG_ACK2, 16'h00FF);
    write_reg(CFG_LIMIT, 16'd1);
    queue_word(ACT_START, 8'h00, 1'b0);
    queue_word(ACT_STRING, 8'h00, 1'b0);
    queue_word(ACT_STRING, 8'hFF, 1'b1);
    queue_word(ACT_START, 8'h00, 1'b0);
    queue_strings(5);
    queue_response(8'h00, 8'hFF, 4);
    queue_word(ACT_FAIL, 8'hFF, 1'b1);
    settle();

    // lengths change while a frame is open
    write_reg(CFG_CID, 16'd1);
    write_reg(CFG_USER, 16'd2);
    write_reg(CFG_PASS, 16'd1);
    queue_word(ACT_START, 8'h00, 1'b0);
    settle();
    write_reg(CFG_USER, 16'd0);
    write_reg(CFG_PASS, 16'd3);
    queue_strings(4);
    settle();

    // largest lengths, failure count saturation
    write_reg(CFG_CID, 16'hFFFF);
    write_reg(CFG_USER, 16'hFFFF);
    write_reg(CFG_PASS, 16'hFFFF);
    write_reg(CFG_ACK1, 16'h00FF);
    write_reg(CFG_ACK2, 16'h0000);
    write_reg(CFG_LIMIT, 16'd15);
    queue_word(ACT_START, 8'h5A, 1'b0);
    queue_strings(3);
    for (int i = 0; i < 17; i++) queue_word(ACT_FAIL, 8'($urandom), 1'($urandom));
    queue_response(8'hFF, 8'h00, 4);
    settle();

    phase = 0;
    while (queued < TOTAL_ITEMS) begin
      foreach (lens[k]) lens[k] = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      write_reg(CFG_CID, lens[0]);
      write_reg(CFG_USER, lens[1]);
      write_reg(CFG_PASS, lens[2]);
      if ($urandom_range(2) == 0) begin
        write_reg(CFG_ACK1, 16'($urandom_range(255)));
        write_reg(CFG_ACK2, 16'($urandom_range(255)));
      end
      write_reg(CFG_LIMIT, (phase == 1) ? 16'd0 : (phase == 2) ? 16'd1
                                                  : 16'($urandom_range(1, 15)));
      steady = (phase == 0);
      // response longer than the collection limit
      if (phase == 2) queue_response(ack1, ack2, 203);
      total = int'(lens[0]) + int'(lens[1]) + int'(lens[2]);
      n = 0;
      while (n < 10) n += queue_sequence(total);
      settle();
      steady = 1'b0;
      phase++;
    end

    if (errors == 0) begin
      $display("mqtt_connect_framer_test: done, clean");
    end else begin
      $display("mqtt_connect_framer_test: done, errors");
    end
    $finish;
  end

endmodule
